/* sv/tems_pkg.sv */
// ----------------------------------------------------------------------------
// tems_pkg
// Shared widths, codes and defaults for the tolerant edge map comparator.
// ----------------------------------------------------------------------------
package tems_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CLASS_W    = 3;
  localparam int COUNT_W    = 23;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 96;

  localparam int MAX_COLS_DEF = 2048;
  localparam int MAX_ROWS_DEF = 2048;
  localparam int COLS_RESET   = 640;
  localparam int ROWS_RESET   = 480;
  localparam int MIN_SIZE     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd1;

  localparam logic [CLASS_W-1:0] CLS_BACKGROUND = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_MATCHED    = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_MISSED     = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_FALSE      = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_NONE       = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // line buffer word: {det two lines back, det one line back,
  //                    truth two lines back, truth one line back}
  localparam int LINE_W = 4;

  typedef logic [COUNT_W-1:0] count_t;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

/* sv/tems_ram.sv */
// ----------------------------------------------------------------------------
// tems_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tems_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/tolerant_edge_map_compare.sv */
// ----------------------------------------------------------------------------
// tolerant_edge_map_compare
// Each pixel pair is registered in stage 1 and then in the output register.
// Throughput: one pixel pair per cycle while the output is not stalled and no clearing sweep runs.
// Reset: synchronous active-low; afterwards the line buffer is swept to zero
// across all MAX_COLS addresses, during which no pixel is accepted.
// Config writes are always taken; sizes are clamped to [3, MAX].
// ----------------------------------------------------------------------------
module tolerant_edge_map_compare #(
  parameter int MAX_COLS = tems_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tems_pkg::MAX_ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] truth_pixel, [15:8] detected_pixel
  input  logic [tems_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [2:0] pixel_class, [25:3] truth_total, [48:26] missed_total,
  // [71:49] background_total, [94:72] false_total, [95] zero
  output logic [tems_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // frame_done
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tems_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tems_pkg::CFG_W-1:0]         cfg_data
);

  localparam int CW     = $clog2(MAX_COLS);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CSZ_W  = $clog2(MAX_COLS + 1);
  localparam int RSZ_W  = $clog2(MAX_ROWS + 1);
  localparam int COLS_INIT = (tems_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS : tems_pkg::COLS_RESET;
  localparam int ROWS_INIT = (tems_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS : tems_pkg::ROWS_RESET;
  localparam int LW     = tems_pkg::LINE_W;

  // configuration
  logic [CSZ_W-1:0] cols_r, cols_nxt;
  logic [RSZ_W-1:0] rows_r, rows_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (cfg_valid && cfg_index == tems_pkg::REG_IMAGE_COLS) begin
      if (cfg_data < tems_pkg::CFG_W'(tems_pkg::MIN_SIZE)) begin
        cols_nxt = CSZ_W'(tems_pkg::MIN_SIZE);
      end else if (32'(cfg_data) > MAX_COLS) begin
        cols_nxt = CSZ_W'(MAX_COLS);
      end else begin
        cols_nxt = CSZ_W'(cfg_data);
      end
    end
    if (cfg_valid && cfg_index == tems_pkg::REG_IMAGE_ROWS) begin
      if (cfg_data < tems_pkg::CFG_W'(tems_pkg::MIN_SIZE)) begin
        rows_nxt = RSZ_W'(tems_pkg::MIN_SIZE);
      end else if (32'(cfg_data) > MAX_ROWS) begin
        rows_nxt = RSZ_W'(MAX_ROWS);
      end else begin
        rows_nxt = RSZ_W'(cfg_data);
      end
    end
  end

  // clearing sweep of the line buffer
  logic          clr_r;
  logic [CW-1:0] clr_addr_r;

  // input stage: position counters
  logic          in_acc;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          line_end, frame_end, interior;

  // stage 1
  logic          s1_v_r;
  logic          s1_adv;
  logic [CW-1:0] s1_col_r;
  logic          s1_t_r, s1_d_r, s1_int_r, s1_fe_r;
  logic [LW-1:0] rd_data;
  logic [LW-1:0] wr_data;
  logic          ram_we;
  logic [CW-1:0] ram_waddr;

  // windows and counts
  logic [8:0]         win_t_r, win_d_r, win_t_nxt, win_d_nxt;
  tems_pkg::count_t   cnt_truth_r, cnt_miss_r, cnt_bg_r, cnt_false_r;
  tems_pkg::count_t   c_truth, c_miss, c_bg, c_false;
  logic [tems_pkg::CLASS_W-1:0] cls;

  // output register
  logic                         out_v_r;
  logic [tems_pkg::CLASS_W-1:0] out_cls_r;
  tems_pkg::count_t             out_truth_r, out_miss_r, out_bg_r, out_false_r;
  logic                         out_last_r;

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !clr_r && (!s1_v_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  assign line_end  = (CSZ_W'(col_r) + 1'b1) >= cols_r;
  assign frame_end = line_end && ((RSZ_W'(row_r) + 1'b1) >= rows_r);
  assign interior  = (col_r >= CW'(2)) && (CSZ_W'(col_r) < cols_r) &&
                     (row_r >= RW'(2)) && (RSZ_W'(row_r) < rows_r);

  // line buffer: bit 0 truth one back, 1 truth two back, 2 det one back, 3 det two back
  assign wr_data   = {rd_data[2], s1_d_r, rd_data[0], s1_t_r};
  assign ram_we    = clr_r || s1_adv;
  assign ram_waddr = clr_r ? clr_addr_r : s1_col_r;

  tems_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (clr_r ? '0 : wr_data),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (rd_data)
  );

  // window shift: bit row*3+col, col 0 newest
  always_comb begin
    win_t_nxt = ((win_t_r << 1) & 9'h1B6) | {2'b00, s1_t_r, 2'b00, rd_data[0], 2'b00, rd_data[1]};
    win_d_nxt = ((win_d_r << 1) & 9'h1B6) | {2'b00, s1_d_r, 2'b00, rd_data[2], 2'b00, rd_data[3]};
  end

  always_comb begin
    cls     = tems_pkg::CLS_NONE;
    c_truth = cnt_truth_r;
    c_miss  = cnt_miss_r;
    c_bg    = cnt_bg_r;
    c_false = cnt_false_r;
    if (s1_int_r) begin
      if (win_t_nxt[4]) begin
        c_truth = tems_pkg::sat_inc(cnt_truth_r);
        if (win_d_nxt != '0) begin
          cls = tems_pkg::CLS_MATCHED;
        end else begin
          cls    = tems_pkg::CLS_MISSED;
          c_miss = tems_pkg::sat_inc(cnt_miss_r);
        end
      end else begin
        c_bg = tems_pkg::sat_inc(cnt_bg_r);
        if (win_d_nxt[4]) begin
          if (win_t_nxt != '0) begin
            cls = tems_pkg::CLS_MATCHED;
          end else begin
            cls     = tems_pkg::CLS_FALSE;
            c_false = tems_pkg::sat_inc(cnt_false_r);
          end
        end else begin
          cls = tems_pkg::CLS_BACKGROUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= CSZ_W'(COLS_INIT);
      rows_r      <= RSZ_W'(ROWS_INIT);
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      win_t_r     <= '0;
      win_d_r     <= '0;
      cnt_truth_r <= '0;
      cnt_miss_r  <= '0;
      cnt_bg_r    <= '0;
      cnt_false_r <= '0;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == CW'(MAX_COLS - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (in_acc) begin
        if (line_end) begin
          col_r <= '0;
          row_r <= frame_end ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (s1_adv) begin
        win_t_r <= win_t_nxt;
        win_d_r <= win_d_nxt;
        if (s1_fe_r) begin
          cnt_truth_r <= '0;
          cnt_miss_r  <= '0;
          cnt_bg_r    <= '0;
          cnt_false_r <= '0;
        end else begin
          cnt_truth_r <= c_truth;
          cnt_miss_r  <= c_miss;
          cnt_bg_r    <= c_bg;
          cnt_false_r <= c_false;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r <= col_r;
      s1_t_r   <= in_tdata[tems_pkg::PIX_W-1:0] != '0;
      s1_d_r   <= in_tdata[2*tems_pkg::PIX_W-1:tems_pkg::PIX_W] != '0;
      s1_int_r <= interior;
      s1_fe_r  <= frame_end;
    end
    if (s1_adv) begin
      out_cls_r   <= cls;
      out_truth_r <= c_truth;
      out_miss_r  <= c_miss;
      out_bg_r    <= c_bg;
      out_false_r <= c_false;
      out_last_r  <= s1_fe_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_false_r, out_bg_r, out_miss_r, out_truth_r, out_cls_r};

endmodule

/* test/tb_tolerant_edge_map_compare.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tolerant_edge_map_compare
// Streams pixel pairs through the tolerant edge map comparator and checks
// every result word against a cycle-free model of the line stores, the 3x3
// windows and the frame counts. The run covers directed 3x3 frames, register
// extremes with clamping, resizing in mid-line and many small random frames
// under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_tolerant_edge_map_compare;

  localparam int MAX_COLS      = tems_pkg::MAX_COLS_DEF;
  localparam int MAX_ROWS      = tems_pkg::MAX_ROWS_DEF;
  localparam int ITEM_TARGET   = 850;
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_NS    = 5_000_000;

  localparam logic [tems_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [tems_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [8:0]                     WIN_KEEP    = 9'h1B6;

  typedef struct packed {
    logic [tems_pkg::CLASS_W-1:0] pclass;
    logic [tems_pkg::COUNT_W-1:0] truth_total;
    logic [tems_pkg::COUNT_W-1:0] missed_total;
    logic [tems_pkg::COUNT_W-1:0] background_total;
    logic [tems_pkg::COUNT_W-1:0] false_total;
    logic                         frame_done;
  } pix_result_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [tems_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [tems_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [tems_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [tems_pkg::CFG_W-1:0]       cfg_data   = '0;

  tolerant_edge_map_compare DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // model of the comparator
  bit               truth_near [MAX_COLS];
  bit               truth_far  [MAX_COLS];
  bit               det_near   [MAX_COLS];
  bit               det_far    [MAX_COLS];
  logic [8:0]       truth_win = '0;
  logic [8:0]       det_win   = '0;
  int unsigned      col_pos   = 0;
  int unsigned      row_pos   = 0;
  int unsigned      cols_used = tems_pkg::COLS_RESET;
  int unsigned      rows_used = tems_pkg::ROWS_RESET;
  logic [tems_pkg::COUNT_W-1:0] truth_tally = '0;
  logic [tems_pkg::COUNT_W-1:0] missed_tally = '0;
  logic [tems_pkg::COUNT_W-1:0] bg_tally = '0;
  logic [tems_pkg::COUNT_W-1:0] false_tally = '0;

  pix_result_t pending_results [$];
  int          items_sent   = 0;
  int          frames_ended = 0;
  int          reg_writes   = 0;
  int          errors       = 0;
  int          burst_left   = 0;

  rx_mode_t    rx_mode   = RX_OPEN;
  int          rx_left   = 0;
  int unsigned rx_phase  = 0;

  function automatic logic [tems_pkg::COUNT_W-1:0] tally_up(
    input logic [tems_pkg::COUNT_W-1:0] v);
    return (v == tems_pkg::COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic int unsigned clamp_size(input logic [tems_pkg::CFG_W-1:0] v,
                                             input int unsigned hi);
    if (v < tems_pkg::MIN_SIZE) return tems_pkg::MIN_SIZE;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic logic [tems_pkg::PIX_W-1:0] edge_pixel(input int density);
    if ($urandom_range(99) < density) return tems_pkg::PIX_W'($urandom_range(255, 1));
    return '0;
  endfunction

  task automatic predict_pixel(input logic [tems_pkg::PIX_W-1:0] tp,
                               input logic [tems_pkg::PIX_W-1:0] dp);
    pix_result_t r;
    bit          t;
    bit          d;
    bit          line_end;
    bit          frame_end;
    int unsigned idx;
    t = (tp != 0);
    d = (dp != 0);
    idx = (col_pos < MAX_COLS) ? col_pos : MAX_COLS - 1;
    truth_win = ((truth_win << 1) & WIN_KEEP) | 9'(truth_far[idx])
                | (9'(truth_near[idx]) << 3) | (9'(t) << 6);
    det_win = ((det_win << 1) & WIN_KEEP) | 9'(det_far[idx])
              | (9'(det_near[idx]) << 3) | (9'(d) << 6);
    truth_far[idx]  = truth_near[idx];
    truth_near[idx] = t;
    det_far[idx]    = det_near[idx];
    det_near[idx]   = d;

    r.pclass = tems_pkg::CLS_NONE;
    if (col_pos >= 2 && col_pos < cols_used && row_pos >= 2 && row_pos < rows_used) begin
      if (truth_win[4]) begin
        truth_tally = tally_up(truth_tally);
        if (det_win != 0) begin
          r.pclass = tems_pkg::CLS_MATCHED;
        end else begin
          r.pclass = tems_pkg::CLS_MISSED;
          missed_tally = tally_up(missed_tally);
        end
      end else begin
        bg_tally = tally_up(bg_tally);
        if (!det_win[4]) begin
          r.pclass = tems_pkg::CLS_BACKGROUND;
        end else if (truth_win != 0) begin
          r.pclass = tems_pkg::CLS_MATCHED;
        end else begin
          r.pclass = tems_pkg::CLS_FALSE;
          false_tally = tally_up(false_tally);
        end
      end
    end

    line_end  = (col_pos + 1 >= cols_used);
    frame_end = line_end && (row_pos + 1 >= rows_used);
    r.truth_total      = truth_tally;
    r.missed_total     = missed_tally;
    r.background_total = bg_tally;
    r.false_total      = false_tally;
    r.frame_done       = frame_end;
    pending_results.push_back(r);

    if (line_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    if (frame_end) begin
      truth_tally  = '0;
      missed_tally = '0;
      bg_tally     = '0;
      false_tally  = '0;
      frames_ended++;
    end
  endtask

  task automatic send_pixel(input logic [tems_pkg::PIX_W-1:0] tp,
                            input logic [tems_pkg::PIX_W-1:0] dp);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {dp, tp};
    do @(posedge clk); while (!in_tready);
    predict_pixel(tp, dp);
    items_sent++;
    burst_left--;
  endtask

  task automatic settle_block();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tems_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tems_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == tems_pkg::REG_IMAGE_COLS) cols_used = clamp_size(val, MAX_COLS);
    else if (idx == tems_pkg::REG_IMAGE_ROWS) rows_used = clamp_size(val, MAX_ROWS);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic finish_frame(input int density);
    while (col_pos != 0 || row_pos != 0) send_pixel(edge_pixel(density), edge_pixel(density));
  endtask

  task automatic send_mask_frame(input logic [8:0] tmask, input logic [8:0] dmask,
                                 input logic [tems_pkg::PIX_W-1:0] tv,
                                 input logic [tems_pkg::PIX_W-1:0] dv);
    for (int k = 0; k < 9; k++) send_pixel(tmask[k] ? tv : '0, dmask[k] ? dv : '0);
  endtask

  // start at the reset size, then shrink below the current column
  task automatic test_reset_size_and_shrink();
    send_pixel(8'h00, 8'hFF);
    send_pixel(8'hFF, 8'h00);
    send_pixel(8'h01, 8'h80);
    send_pixel(8'h80, 8'h01);
    settle_block();
    write_reg(tems_pkg::REG_IMAGE_COLS, 12'd0);
    write_reg(tems_pkg::REG_IMAGE_ROWS, 12'd2);
    finish_frame(0);
  endtask

  task automatic test_directed_windows();
    send_mask_frame(9'h010, 9'h001, 8'hFF, 8'h01);
    send_mask_frame(9'h010, 9'h000, 8'h7F, 8'hFE);
  endtask

  task automatic test_size_extremes();
    settle_block();
    write_reg(tems_pkg::REG_IMAGE_COLS, 12'hFFF);
    write_reg(tems_pkg::REG_IMAGE_ROWS, 12'hFFF);
    repeat (20) send_pixel(edge_pixel(50), edge_pixel(50));
    settle_block();
    write_reg(REG_SPARE_2, tems_pkg::CFG_W'($urandom));
    write_reg(REG_SPARE_3, tems_pkg::CFG_W'($urandom));
    repeat (5) send_pixel(edge_pixel(50), edge_pixel(50));
    settle_block();
    write_reg(tems_pkg::REG_IMAGE_COLS, 12'd5);
    write_reg(tems_pkg::REG_IMAGE_ROWS, 12'd4);
    finish_frame(40);
  endtask

  task automatic test_random_frames();
    int cols;
    int rows;
    int frames;
    int npix;
    int t_dens;
    int d_dens;
    while (items_sent < ITEM_TARGET) begin
      settle_block();
      if ($urandom_range(7) == 0) begin
        cols   = $urandom_range(64, 11);
        rows   = $urandom_range(5, 3);
        frames = 1;
      end else begin
        cols   = $urandom_range(10, 3);
        rows   = $urandom_range(8, 3);
        frames = $urandom_range(3, 1);
      end
      if ($urandom_range(1)) begin
        write_reg(tems_pkg::REG_IMAGE_COLS, tems_pkg::CFG_W'(cols));
        write_reg(tems_pkg::REG_IMAGE_ROWS, tems_pkg::CFG_W'(rows));
      end else begin
        write_reg(tems_pkg::REG_IMAGE_ROWS, tems_pkg::CFG_W'(rows));
        write_reg(tems_pkg::REG_IMAGE_COLS, tems_pkg::CFG_W'(cols));
      end
      t_dens = $urandom_range(60, 3);
      d_dens = $urandom_range(60, 3);
      finish_frame(t_dens);
      npix = frames * cols * rows;
      if ($urandom_range(5) == 0) npix = $urandom_range(npix - 1, 1);
      repeat (npix) send_pixel(edge_pixel(t_dens), edge_pixel(d_dens));
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(3));
      rx_left <= $urandom_range(120, 20);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= $urandom_range(1);
      RX_SPARSE: out_tready <= ($urandom_range(3) == 0);
      default:   out_tready <= rx_phase[2];
    endcase
  end

  always @(posedge clk) begin : check_results
    pix_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[2:0] !== exp_r.pclass) begin
          $error("pixel_class expected %0d actual %0d", exp_r.pclass, out_tdata[2:0]);
          errors++;
        end
        if (out_tdata[25:3] !== exp_r.truth_total) begin
          $error("truth_total expected %0d actual %0d", exp_r.truth_total, out_tdata[25:3]);
          errors++;
        end
        if (out_tdata[48:26] !== exp_r.missed_total) begin
          $error("missed_total expected %0d actual %0d", exp_r.missed_total, out_tdata[48:26]);
          errors++;
        end
        if (out_tdata[71:49] !== exp_r.background_total) begin
          $error("background_total expected %0d actual %0d",
                 exp_r.background_total, out_tdata[71:49]);
          errors++;
        end
        if (out_tdata[94:72] !== exp_r.false_total) begin
          $error("false_total expected %0d actual %0d", exp_r.false_total, out_tdata[94:72]);
          errors++;
        end
        if (out_tlast !== exp_r.frame_done) begin
          $error("frame_done expected %0d actual %0d", exp_r.frame_done, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_size_and_shrink();
    test_directed_windows();
    test_size_extremes();
    test_random_frames();
    settle_block();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    $display("covered %0d pixel pairs, %0d completed frames, %0d register writes",
             items_sent, frames_ended, reg_writes);
    $display("sizes from 3x3 up to clamped 2048x2048, resizing past the current position");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
sv/tems_pkg.sv
sv/tems_ram.sv
sv/tolerant_edge_map_compare.sv
test/tb_tolerant_edge_map_compare.sv
